### sv/adam_pkg.sv
// ----------------------------------------------------------------------------
// adam_pkg
// Shared sizes, register codes and the records that travel between the
// moment stage and the correction pipeline of the optimizer update block.
// ----------------------------------------------------------------------------
package adam_pkg;

    // store depth and address width
    localparam int NUM_WEIGHTS = 4096;
    localparam int ADDR_W      = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    // field widths
    localparam int IDX_W  = 12;
    localparam int GRAD_W = 32;
    localparam int M_W    = 32;
    localparam int V_W    = 48;
    localparam int PW_W   = 17;
    localparam int CFG_W  = 32;

    // one in Q1.16
    localparam logic [PW_W-1:0] ONE_Q16 = 17'h10000;

    // register reset values
    localparam logic [15:0] BETA_ONE_RST = 16'd58982;
    localparam logic [15:0] BETA_TWO_RST = 16'd65470;
    localparam logic [31:0] EPS_RST      = 32'd429;
    localparam logic [23:0] LR_RST       = 24'd16777;

    // register indexes
    typedef enum logic [1:0] {
        CFG_BETA_ONE,
        CFG_BETA_TWO,
        CFG_EPS,
        CFG_LR
    } t_cfg_idx;

    // request into the moment stage
    typedef struct packed {
        logic                     valid;
        logic                     in_range;
        logic [IDX_W-1:0]         idx;
        logic signed [GRAD_W-1:0] grad;
        logic [PW_W-1:0]          pw1;
        logic [PW_W-1:0]          pw2;
    } t_in_req;

    // updated moments and bias divisors
    typedef struct packed {
        logic                  valid;
        logic                  in_range;
        logic [IDX_W-1:0]      idx;
        logic signed [M_W-1:0] m;
        logic [V_W-1:0]        v;
        logic [PW_W-1:0]       d1;
        logic [PW_W-1:0]       d2;
    } t_mom_item;

    // final update
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] delta;
        logic               clip;
    } t_result;

endpackage

### sv/adam_moment.sv
// ----------------------------------------------------------------------------
// adam_moment
// Moment stores with read-modify-write update, next-item forwarding and the
// clearing sweep after reset. Three stages: gradient products, squared
// gradient product, moment update and write back.
// ----------------------------------------------------------------------------
module adam_moment (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  adam_pkg::t_in_req   i_req,
    input  logic [15:0]         i_beta_one,
    input  logic [15:0]         i_beta_two,
    output logic                o_busy,
    output adam_pkg::t_mom_item o_item
);
    import adam_pkg::*;

    typedef struct packed {
        logic                     valid;
        logic                     in_range;
        logic [IDX_W-1:0]         idx;
        logic signed [GRAD_W-1:0] grad;
        logic [PW_W-1:0]          pw1;
        logic [PW_W-1:0]          pw2;
    } t_s1;

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [IDX_W-1:0]   idx;
        logic signed [49:0] pm2;
        logic [62:0]        gg;
        logic [PW_W-1:0]    d1;
        logic [PW_W-1:0]    d2;
    } t_s2;

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [IDX_W-1:0]   idx;
        logic signed [49:0] pm2;
        logic [63:0]        pv2;
        logic [PW_W-1:0]    d1;
        logic [PW_W-1:0]    d2;
    } t_s3;

    t_s1       r_s1;
    t_s2       r_s2, n_s2;
    t_s3       r_s3, n_s3;
    t_mom_item r_s4, n_s4;

    logic [M_W-1:0]    r_mem_m [NUM_WEIGHTS];
    logic [V_W-1:0]    r_mem_v [NUM_WEIGHTS];
    logic [M_W-1:0]    r_rd_m;
    logic [V_W-1:0]    r_rd_v;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [PW_W-1:0]       omb1, omb2;
    logic signed [63:0]    gg_full;
    logic [46:0]           g2;
    logic                  fwd;
    logic signed [M_W-1:0] m_old;
    logic [V_W-1:0]        v_old;
    logic signed [48:0]    pm1;
    logic signed [49:0]    msum;
    logic [63:0]           pv1, vsum;
    logic                  w_en;
    logic [ADDR_W-1:0]     w_addr;
    logic [M_W-1:0]        w_m;
    logic [V_W-1:0]        w_v;

    assign omb1 = ONE_Q16 - {1'b0, i_beta_one};
    assign omb2 = ONE_Q16 - {1'b0, i_beta_two};

    // stage one: gradient products and bias divisors
    always_comb begin
        gg_full    = r_s1.grad * r_s1.grad;
        n_s2.valid    = r_s1.valid;
        n_s2.in_range = r_s1.in_range;
        n_s2.idx      = r_s1.idx;
        n_s2.pm2      = $signed({1'b0, omb1}) * r_s1.grad;
        n_s2.gg       = gg_full[62:0];
        n_s2.d1       = (r_s1.pw1 == ONE_Q16) ? ONE_Q16 : ONE_Q16 - r_s1.pw1;
        n_s2.d2       = (r_s1.pw2 == ONE_Q16) ? ONE_Q16 : ONE_Q16 - r_s1.pw2;
    end

    // stage two: decayed squared gradient term
    always_comb begin
        g2 = r_s2.gg[62:16];
        n_s3.valid    = r_s2.valid;
        n_s3.in_range = r_s2.in_range;
        n_s3.idx      = r_s2.idx;
        n_s3.pm2      = r_s2.pm2;
        n_s3.pv2      = 64'(omb2) * 64'(g2);
        n_s3.d1       = r_s2.d1;
        n_s3.d2       = r_s2.d2;
    end

    // stage three: moment update, previous item forwarded on same index
    always_comb begin
        fwd   = r_s4.valid && r_s4.in_range && (r_s4.idx == r_s3.idx);
        m_old = fwd ? r_s4.m : $signed(r_rd_m);
        v_old = fwd ? r_s4.v : r_rd_v;
        pm1   = $signed({1'b0, i_beta_one}) * m_old;
        msum  = 50'(pm1) + r_s3.pm2;
        pv1   = 64'(i_beta_two) * 64'(v_old);
        vsum  = pv1 + r_s3.pv2;
        n_s4.valid    = r_s3.valid;
        n_s4.in_range = r_s3.in_range;
        n_s4.idx      = r_s3.idx;
        n_s4.m        = msum[47:16];
        n_s4.v        = vsum[63:16];
        n_s4.d1       = r_s3.d1;
        n_s4.d2       = r_s3.d2;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= t_s1'(i_req);
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(NUM_WEIGHTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port select
    always_comb begin
        w_en   = r_clr_busy || (i_adv && r_s3.valid && r_s3.in_range);
        w_addr = r_clr_busy ? r_clr_addr : ADDR_W'(r_s3.idx);
        w_m    = r_clr_busy ? '0 : n_s4.m;
        w_v    = r_clr_busy ? '0 : n_s4.v;
    end

    // moment stores
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem_m[w_addr] <= w_m;
            r_mem_v[w_addr] <= w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_m <= r_mem_m[ADDR_W'(r_s2.idx)];
            r_rd_v <= r_mem_v[ADDR_W'(r_s2.idx)];
        end
    end

    assign o_busy = r_clr_busy;
    assign o_item = r_s4;

endmodule

### sv/adam_corr.sv
// ----------------------------------------------------------------------------
// adam_corr
// Bias correction, root and step scaling as one long pipeline: two
// restoring dividers side by side, a root extractor, the learning rate
// product and a final divider with saturation.
// ----------------------------------------------------------------------------
module adam_corr (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  adam_pkg::t_mom_item i_item,
    input  logic [31:0]         i_eps,
    input  logic [23:0]         i_lr,
    output adam_pkg::t_result   o_res
);
    import adam_pkg::*;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int QD_STEPS   = 33;

    localparam logic [32:0]        POS_LIMIT = 33'h080000000;
    localparam logic [32:0]        NEG_LIMIT = 33'h07FFFFFFF;
    localparam logic signed [31:0] DELTA_MIN = 32'sh80000000;
    localparam logic signed [31:0] DELTA_MAX = 32'sh7FFFFFFF;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic [PW_W-1:0]  d1;
        logic [PW_W-1:0]  d2;
        logic [16:0]      ra;
        logic [63:0]      nqa;
        logic [16:0]      rb;
        logic [63:0]      nqb;
    } t_dv;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic [47:0]      amag;
        logic [63:0]      s;
    } t_se;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic [47:0]      amag;
        logic [35:0]      rem;
        logic [31:0]      root;
        logic [63:0]      s;
    } t_sq;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic [31:0]      r;
        logic [47:0]      pl;
        logic [47:0]      ph;
    } t_mu;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic [31:0]      r;
        logic [62:0]      np;
    } t_sm;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic             ovf;
        logic [31:0]      r;
        logic [31:0]      rem;
        logic [32:0]      nq;
    } t_qd;

    // one quotient bit of both bias dividers
    function automatic t_dv dv_next(t_dv x);
        t_dv         y;
        logic [17:0] ta, tb;
        logic        qa, qb;
        y  = x;
        ta = {x.ra, x.nqa[63]};
        qa = (ta >= {1'b0, x.d1});
        if (qa) ta = ta - {1'b0, x.d1};
        tb = {x.rb, x.nqb[63]};
        qb = (tb >= {1'b0, x.d2});
        if (qb) tb = tb - {1'b0, x.d2};
        y.ra  = ta[16:0];
        y.nqa = {x.nqa[62:0], qa};
        y.rb  = tb[16:0];
        y.nqb = {x.nqb[62:0], qb};
        return y;
    endfunction

    // one root bit
    function automatic t_sq sq_next(t_sq x);
        t_sq         y;
        logic [35:0] t, trial;
        logic        b;
        y     = x;
        t     = {x.rem[33:0], x.s[63:62]};
        trial = {2'b00, x.root, 2'b01};
        b     = (t >= trial);
        if (b) t = t - trial;
        y.rem  = t;
        y.root = {x.root[30:0], b};
        y.s    = {x.s[61:0], 2'b00};
        return y;
    endfunction

    // one quotient bit of the step divider
    function automatic t_qd qd_next(t_qd x);
        t_qd         y;
        logic [32:0] t;
        logic        q;
        y = x;
        t = {x.rem, x.nq[32]};
        q = (t >= {1'b0, x.r});
        if (q) t = t - {1'b0, x.r};
        y.rem = t[31:0];
        y.nq  = {x.nq[31:0], q};
        return y;
    endfunction

    t_dv     r_dv [DIV_STEPS+1];
    t_se     r_se;
    t_sq     r_sq [SQRT_STEPS+1];
    t_mu     r_mu;
    t_sm     r_sm;
    t_qd     r_qd [QD_STEPS+1];
    t_result r_out;

    t_dv         n_dv0;
    t_se         n_se;
    t_sq         n_sq0;
    t_mu         n_mu;
    t_sm         n_sm;
    t_qd         n_qd0;
    t_result     n_out;
    logic [31:0] m_abs;
    logic [64:0] s_sum;
    logic [71:0] prod;
    logic [32:0] mag;

    // divider setup: |m| << 16 over d1, v << 16 over d2
    always_comb begin
        m_abs = i_item.m[M_W-1] ? 32'(-i_item.m) : 32'(i_item.m);
        n_dv0.valid    = i_item.valid;
        n_dv0.in_range = i_item.in_range;
        n_dv0.neg      = i_item.m[M_W-1];
        n_dv0.idx      = i_item.idx;
        n_dv0.d1       = i_item.d1;
        n_dv0.d2       = i_item.d2;
        n_dv0.ra       = '0;
        n_dv0.nqa      = {16'd0, m_abs, 16'd0};
        n_dv0.rb       = '0;
        n_dv0.nqb      = {i_item.v, 16'd0};
    end

    // epsilon add, saturating
    always_comb begin
        s_sum = {1'b0, r_dv[DIV_STEPS].nqb} + {33'd0, i_eps};
        n_se.valid    = r_dv[DIV_STEPS].valid;
        n_se.in_range = r_dv[DIV_STEPS].in_range;
        n_se.neg      = r_dv[DIV_STEPS].neg;
        n_se.idx      = r_dv[DIV_STEPS].idx;
        n_se.amag     = r_dv[DIV_STEPS].nqa[47:0];
        n_se.s        = s_sum[64] ? '1 : s_sum[63:0];
    end

    // root setup
    always_comb begin
        n_sq0.valid    = r_se.valid;
        n_sq0.in_range = r_se.in_range;
        n_sq0.neg      = r_se.neg;
        n_sq0.idx      = r_se.idx;
        n_sq0.amag     = r_se.amag;
        n_sq0.rem      = '0;
        n_sq0.root     = '0;
        n_sq0.s        = r_se.s;
    end

    // learning rate partial products, zero root taken as one
    always_comb begin
        n_mu.valid    = r_sq[SQRT_STEPS].valid;
        n_mu.in_range = r_sq[SQRT_STEPS].in_range;
        n_mu.neg      = r_sq[SQRT_STEPS].neg;
        n_mu.idx      = r_sq[SQRT_STEPS].idx;
        n_mu.r        = (r_sq[SQRT_STEPS].root == '0) ? 32'd1 : r_sq[SQRT_STEPS].root;
        n_mu.pl       = 48'(r_sq[SQRT_STEPS].amag[23:0]) * 48'(i_lr);
        n_mu.ph       = 48'(r_sq[SQRT_STEPS].amag[47:24]) * 48'(i_lr);
    end

    // full product, the factor 256 of the divisor folded in as a shift
    always_comb begin
        prod = {r_mu.ph, 24'd0} + {24'd0, r_mu.pl};
        n_sm.valid    = r_mu.valid;
        n_sm.in_range = r_mu.in_range;
        n_sm.neg      = r_mu.neg;
        n_sm.idx      = r_mu.idx;
        n_sm.r        = r_mu.r;
        n_sm.np       = prod[70:8];
    end

    // step divider setup, overflow when the quotient needs more than 33 bits
    always_comb begin
        n_qd0.valid    = r_sm.valid;
        n_qd0.in_range = r_sm.in_range;
        n_qd0.neg      = r_sm.neg;
        n_qd0.idx      = r_sm.idx;
        n_qd0.ovf      = ({2'b00, r_sm.np[62:33]} >= r_sm.r);
        n_qd0.r        = r_sm.r;
        n_qd0.rem      = {2'b00, r_sm.np[62:33]};
        n_qd0.nq       = r_sm.np[32:0];
    end

    // sign and saturation
    always_comb begin
        mag = r_qd[QD_STEPS].nq;
        n_out.valid = r_qd[QD_STEPS].valid;
        n_out.idx   = r_qd[QD_STEPS].idx;
        n_out.delta = '0;
        n_out.clip  = 1'b0;
        if (r_qd[QD_STEPS].in_range) begin
            if (!r_qd[QD_STEPS].neg) begin
                if (r_qd[QD_STEPS].ovf || (mag > POS_LIMIT)) begin
                    n_out.delta = DELTA_MIN;
                    n_out.clip  = 1'b1;
                end else begin
                    n_out.delta = -$signed(mag[31:0]);
                end
            end else begin
                if (r_qd[QD_STEPS].ovf || (mag > NEG_LIMIT)) begin
                    n_out.delta = DELTA_MAX;
                    n_out.clip  = 1'b1;
                end else begin
                    n_out.delta = $signed(mag[31:0]);
                end
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_dv[k].valid <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) r_sq[k].valid <= 1'b0;
            for (int k = 0; k <= QD_STEPS; k++) r_qd[k].valid <= 1'b0;
            r_se.valid  <= 1'b0;
            r_mu.valid  <= 1'b0;
            r_sm.valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_dv[0] <= n_dv0;
            for (int k = 0; k < DIV_STEPS; k++) r_dv[k+1] <= dv_next(r_dv[k]);
            r_se    <= n_se;
            r_sq[0] <= n_sq0;
            for (int k = 0; k < SQRT_STEPS; k++) r_sq[k+1] <= sq_next(r_sq[k]);
            r_mu    <= n_mu;
            r_sm    <= n_sm;
            r_qd[0] <= n_qd0;
            for (int k = 0; k < QD_STEPS; k++) r_qd[k+1] <= qd_next(r_qd[k]);
            r_out   <= n_out;
        end
    end

    assign o_res = r_out;

endmodule

### sv/adam_optimizer_update.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Adam weight update, one gradient element per request, fixed point.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries weight index, Q8.24 gradient and
// a pass start mark. A request is taken at an edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carries the index, the
// saturated Q8.24 delta and the clip flag.
// One request per cycle is taken while o_stall is low, any index order,
// repeats included: the moment update forwards the previous request's
// result on the same index. The pipeline depth comes from the two 64-step
// bias dividers, the 32-step root and the 33-step step divider, one bit
// per stage.
// The whole pipeline holds while a result waits under i_stall; nothing is
// lost or repeated.
// After reset the moment stores are swept to zero, one entry a cycle, over
// all 4096 entries with o_stall high; register writes are taken meanwhile.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module adam_optimizer_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [adam_pkg::IDX_W-1:0]     i_weight_index,
    input  logic signed [adam_pkg::GRAD_W-1:0] i_grad_value,
    input  logic                           i_pass_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [adam_pkg::IDX_W-1:0]     o_out_index,
    output logic signed [31:0]             o_weight_delta,
    output logic                           o_clipped,
    input  logic                           i_cfg_we,
    input  adam_pkg::t_cfg_idx             i_cfg_index,
    input  logic [adam_pkg::CFG_W-1:0]     i_cfg_data
);
    import adam_pkg::*;

    logic [15:0]     r_beta_one, r_beta_two;
    logic [31:0]     r_eps;
    logic [23:0]     r_lr;
    logic [PW_W-1:0] r_pw1, r_pw2, n_pw1, n_pw2;

    logic        adv, busy, accept;
    logic [32:0] pp1, pp2;
    t_in_req     req;
    t_mom_item   mom;
    t_result     res;

    // pipeline moves unless a finished result is held
    assign adv     = !(res.valid && i_stall);
    assign o_stall = !adv || busy;
    assign accept  = i_valid && !o_stall;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_one <= BETA_ONE_RST;
            r_beta_two <= BETA_TWO_RST;
            r_eps      <= EPS_RST;
            r_lr       <= LR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BETA_ONE: r_beta_one <= i_cfg_data[15:0];
                CFG_BETA_TWO: r_beta_two <= i_cfg_data[15:0];
                CFG_EPS:      r_eps      <= i_cfg_data[31:0];
                CFG_LR:       r_lr       <= i_cfg_data[23:0];
            endcase
        end
    end

    // running beta powers, stepped on a pass start
    always_comb begin
        pp1   = 33'(r_pw1) * 33'(r_beta_one);
        pp2   = 33'(r_pw2) * 33'(r_beta_two);
        n_pw1 = i_pass_start ? pp1[32:16] : r_pw1;
        n_pw2 = i_pass_start ? pp2[32:16] : r_pw2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw1 <= ONE_Q16;
            r_pw2 <= ONE_Q16;
        end else if (accept) begin
            r_pw1 <= n_pw1;
            r_pw2 <= n_pw2;
        end
    end

    // request into the moment stage
    always_comb begin
        req.valid    = i_valid && !busy;
        req.in_range = ({20'd0, i_weight_index} < 32'(NUM_WEIGHTS));
        req.idx      = i_weight_index;
        req.grad     = i_grad_value;
        req.pw1      = n_pw1;
        req.pw2      = n_pw2;
    end

    adam_moment u_moment (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_req      (req),
        .i_beta_one (r_beta_one),
        .i_beta_two (r_beta_two),
        .o_busy     (busy),
        .o_item     (mom)
    );

    adam_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (mom),
        .i_eps   (r_eps),
        .i_lr    (r_lr),
        .o_res   (res)
    );

    assign o_valid        = res.valid;
    assign o_out_index    = res.idx;
    assign o_weight_delta = res.delta;
    assign o_clipped      = res.clip;

endmodule
